// ===== rtl/pmr_pkg.sv =====
package pmr_pkg;
	localparam int MaxPixels = 4096;
	localparam int MaxImages = 32;
	localparam int PosW = $clog2(MaxPixels);
	localparam int CntW = 13;
	localparam int IdxW = $clog2(MaxImages);
	localparam int TotW = IdxW + 1;
	localparam int PixW = 24;
	localparam logic [CntW-1:0] PixelsReset = 13'd2500;

	typedef enum logic [1:0] {
		CMD_QUERY = 2'd0,
		CMD_DB = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_EMIT,
		ST_EMPTY
	} state_t;
endpackage

// ===== rtl/pixel_match_ranking.sv =====
// Pixel match ranking.
// Input channel (in_valid/in_stall, command, pixel): command 0 writes a query
// pixel, 1 compares a database pixel against the query pixel at the same
// position, 2 emits the ranking. Config: image_pixels_we/image_pixels_wd set
// pixels per image (0 acts as 1, above 4096 acts as 4096).
// Output channel (out_valid/out_stall): one item per stored image, largest
// match count first, ties to lower index; last marks the final item. With no
// stored image one item with empty_res set is sent.
// A query pixel is written as it is accepted; a database pixel stalls the input
// while the registered query memory read is compared and counted.
// Finish selects each output by one scan over the score memory's single read
// port, and the input stalls until the last item is sent.
// Reset clears positions, counters and flags; the memories are not cleared.
// While the receiver stalls, the output item holds and the scan waits.
module pixel_match_ranking (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] command,
	input logic [23:0] pixel,
	input logic image_pixels_we,
	input logic [12:0] image_pixels_wd,
	output logic out_valid,
	input logic out_stall,
	output logic [4:0] image_index,
	output logic [12:0] match_count,
	output logic empty_res,
	output logic dropped,
	output logic last
);
	import pmr_pkg::*;

	state_t state_q, state_d;
	logic [CntW-1:0] npix_q;
	logic [PosW-1:0] qpos_q, dpos_q;
	logic [CntW-1:0] run_q;
	logic [TotW-1:0] total_q;
	logic ovf_q;
	logic [PixW-1:0] pix_q;
	logic dend_q;
	logic [MaxImages-1:0] done_q;   // images already sent
	logic [TotW-1:0] scan_q;        // address being read
	logic [TotW-1:0] emitted_q;
	logic best_ok_q;
	logic [IdxW-1:0] best_idx_q;
	logic [CntW-1:0] best_cnt_q;
	logic [IdxW-1:0] rd_idx_q;
	logic rd_ok_q;

	logic [PosW:0] n;
	logic [PixW-1:0] q_rdata;
	logic [CntW-1:0] s_rdata;
	logic accept, q_we, s_we;
	logic [IdxW-1:0] s_raddr;

	// Effective size clamped to 1..MaxPixels.
	always_comb begin
		if (npix_q == '0) n = (PosW+1)'(1);
		else if (npix_q > CntW'(MaxPixels)) n = (PosW+1)'(MaxPixels);
		else n = npix_q[PosW:0];
	end

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign q_we = accept && (cmd_t'(command) == CMD_QUERY);
	assign s_raddr = scan_q[IdxW-1:0];

	logic cmp_hit;
	logic [CntW-1:0] run_inc;
	assign cmp_hit = (q_rdata == pix_q);
	assign run_inc = run_q + CntW'(cmp_hit);
	assign s_we = (state_q == ST_CMP) && dend_q && (total_q < TotW'(MaxImages));

	pmr_query_ram u_qram (
		.clk(clk), .we(q_we), .waddr(qpos_q), .wdata(pixel),
		.raddr(dpos_q), .rdata(q_rdata)
	);
	pmr_score_ram u_sram (
		.clk(clk), .we(s_we), .waddr(total_q[IdxW-1:0]), .wdata(run_inc),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd_t'(command) == CMD_DB) state_d = ST_CMP;
				else if (accept && cmd_t'(command) == CMD_FINISH)
					state_d = (total_q == '0) ? ST_EMPTY : ST_SCAN;
			end
			ST_CMP: state_d = ST_IDLE;
			ST_SCAN: if (scan_q == total_q) state_d = ST_SCAN_WAIT;
			ST_SCAN_WAIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_stall)
					state_d = (emitted_q + 1'b1 == total_q) ? ST_IDLE : ST_SCAN;
			end
			ST_EMPTY: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		out_valid = (state_q == ST_EMIT) || (state_q == ST_EMPTY);
		empty_res = (state_q == ST_EMPTY);
		image_index = (state_q == ST_EMIT) ? best_idx_q : '0;
		match_count = (state_q == ST_EMIT) ? best_cnt_q : '0;
		dropped = ovf_q;
		last = (state_q == ST_EMPTY) || (emitted_q + 1'b1 == total_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			npix_q <= PixelsReset;
			qpos_q <= '0;
			dpos_q <= '0;
			run_q <= '0;
			total_q <= '0;
			ovf_q <= 1'b0;
			dend_q <= 1'b0;
			done_q <= '0;
			scan_q <= '0;
			emitted_q <= '0;
			best_ok_q <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (image_pixels_we) npix_q <= image_pixels_wd;
			unique case (state_q)
				ST_IDLE: begin
					if (q_we)
						qpos_q <= ((PosW+1)'(qpos_q) + 1'b1 >= n) ? '0 : qpos_q + 1'b1;
					if (accept && cmd_t'(command) == CMD_DB) begin
						dend_q <= ((PosW+1)'(dpos_q) + 1'b1 >= n);
					end
					if (accept && cmd_t'(command) == CMD_FINISH) begin
						done_q <= '0;
						scan_q <= '0;
						emitted_q <= '0;
						best_ok_q <= 1'b0;
						rd_ok_q <= 1'b0;
					end
				end
				ST_CMP: begin
					if (dend_q) begin
						run_q <= '0;
						dpos_q <= '0;
						if (total_q < TotW'(MaxImages)) total_q <= total_q + 1'b1;
						else ovf_q <= 1'b1;
					end else begin
						run_q <= run_inc;
						dpos_q <= dpos_q + 1'b1;
					end
				end
				ST_SCAN, ST_SCAN_WAIT: begin
					// Data for rd_idx_q arrives now; fold into the best pick.
					if (rd_ok_q && !done_q[rd_idx_q] &&
					    (!best_ok_q || s_rdata > best_cnt_q)) begin
						best_ok_q <= 1'b1;
						best_idx_q <= rd_idx_q;
						best_cnt_q <= s_rdata;
					end
					rd_idx_q <= s_raddr;
					rd_ok_q <= (state_q == ST_SCAN) && (scan_q != total_q);
					if (state_q == ST_SCAN && scan_q != total_q) scan_q <= scan_q + 1'b1;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						done_q[best_idx_q] <= 1'b1;
						emitted_q <= emitted_q + 1'b1;
						best_ok_q <= 1'b0;
						rd_ok_q <= 1'b0;
						scan_q <= '0;
						if (emitted_q + 1'b1 == total_q) begin
							total_q <= '0;
							ovf_q <= 1'b0;
							dpos_q <= '0;
							run_q <= '0;
						end
					end
				end
				ST_EMPTY: begin
					if (!out_stall) begin
						ovf_q <= 1'b0;
						dpos_q <= '0;
						run_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) pix_q <= pixel;
	end
endmodule

// ===== rtl/pmr_query_ram.sv =====
module pmr_query_ram (
	input logic clk,
	input logic we,
	input logic [pmr_pkg::PosW-1:0] waddr,
	input logic [pmr_pkg::PixW-1:0] wdata,
	input logic [pmr_pkg::PosW-1:0] raddr,
	output logic [pmr_pkg::PixW-1:0] rdata
);
	import pmr_pkg::*;
	logic [PixW-1:0] mem [MaxPixels];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/pmr_score_ram.sv =====
module pmr_score_ram (
	input logic clk,
	input logic we,
	input logic [pmr_pkg::IdxW-1:0] waddr,
	input logic [pmr_pkg::CntW-1:0] wdata,
	input logic [pmr_pkg::IdxW-1:0] raddr,
	output logic [pmr_pkg::CntW-1:0] rdata
);
	import pmr_pkg::*;
	logic [CntW-1:0] mem [MaxImages];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/pmr_checker.sv =====
module pmr_props (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [4:0] image_index,
	input logic [12:0] match_count,
	input logic empty_res,
	input logic last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(image_index) && $stable(match_count))
		else $error("output item changed while stalled");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last && match_count == 13'd0)
		else $error("empty item not final");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during ranking");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_count <= 13'd4096)
		else $error("count out of range");
endmodule

bind pixel_match_ranking pmr_props u_pmr_props (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .image_index(image_index),
	.match_count(match_count), .empty_res(empty_res), .last(last)
);
